// ===== src/bnf_pkg.sv =====
// ---------------------------------------------------------------------------
// bnf_pkg
// Shared types, codes and IEEE single helpers for the batch-norm fold unit.
// ---------------------------------------------------------------------------
package bnf_pkg;

	localparam int IN_DATA_W  = 208;
	localparam int OUT_DATA_W = 32;
	localparam int CFG_IDX_W  = 2;

	localparam logic [CFG_IDX_W-1:0] REG_EPSILON = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RESCALE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_AFFINE  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BIAS    = 2'd3;

	localparam logic [31:0] EPSILON_RST = 32'h3727C5AC;
	localparam logic [31:0] RESCALE_RST = 32'h3F800000;
	localparam logic [31:0] FP_ONE      = 32'h3F800000;
	localparam logic [31:0] FP_CNAN     = 32'h7FC00000;

	localparam logic KIND_BIAS   = 1'b0;
	localparam logic KIND_WEIGHT = 1'b1;

	localparam logic [1:0] FOP_MUL  = 2'd0;
	localparam logic [1:0] FOP_ADD  = 2'd1;
	localparam logic [1:0] FOP_DIV  = 2'd2;
	localparam logic [1:0] FOP_SQRT = 2'd3;

	typedef struct packed {
		logic        start;
		logic [1:0]  op;
		logic [31:0] a;
		logic [31:0] b;
	} fpu_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] value;
	} fpu_rsp_t;

	typedef struct packed {
		logic        sign;
		logic [12:0] exp;
		logic [23:0] mant;
		logic        zero;
		logic        inf;
		logic        nan;
	} fp_unp_t;

	function automatic logic [4:0] lzc28(input logic [27:0] v);
		logic [4:0] n;
		n = 5'd28;
		for (int i = 0; i < 28; i++) begin
			if (v[i]) n = 5'(27 - i);
		end
		return n;
	endfunction

	function automatic fp_unp_t fp_unpack(input logic [31:0] b);
		fp_unp_t u;
		logic [4:0] lz;
		lz = lzc28({1'b0, b[22:0], 4'b0});
		u.sign = b[31];
		u.nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
		u.inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
		u.zero = (b[30:0] == 31'd0);
		if (b[30:23] != 8'd0) begin
			u.mant = {1'b1, b[22:0]};
			u.exp  = {5'd0, b[30:23]};
		end else begin
			u.mant = {1'b0, b[22:0]} << lz;
			u.exp  = 13'd1 - {8'd0, lz};
		end
		return u;
	endfunction

	function automatic logic [31:0] fp_round(input logic sign, input logic signed [12:0] exp,
		input logic [26:0] sig, input logic sticky);
		logic [12:0] sh;
		logic [12:0] ebase;
		logic [4:0]  sh5;
		logic [58:0] w;
		logic [26:0] s2;
		logic        st;
		logic [23:0] keep;
		logic        up;
		logic [33:0] t;
		logic [31:0] res;
		if (exp >= 13'sd1) begin
			sh    = 13'd0;
			ebase = $unsigned(exp);
		end else begin
			sh    = 13'd1 - $unsigned(exp);
			ebase = 13'd1;
		end
		sh5  = (sh > 13'd31) ? 5'd31 : sh[4:0];
		w    = {sig, 32'd0} >> sh5;
		s2   = w[58:32];
		st   = sticky | (|w[31:0]);
		keep = s2[26:3];
		up   = s2[2] & (s2[1] | s2[0] | st | keep[0]);
		t    = (34'(ebase - 13'd1) << 23) + 34'(keep) + 34'(up);
		if (t >= 34'h07F800000) res = {sign, 8'hFF, 23'd0};
		else res = {sign, t[30:0]};
		return res;
	endfunction

endpackage

// ===== src/batch_norm_fold_into_weights_unit.sv =====
// Weight request: the result time is set by the RAM read overlapping the issue of the multiply,
// one multiply pass and the output register; no new request is taken until the result is registered.
// Statistics request: the result time is set by up to two iterative divides, one iterative
// square root, up to eight multiply/add passes and the output register; the unit is ready for
// the next request in the same cycle as the result is presented. The output step waits while an earlier result is held.
// Reset clears control and restores the configuration defaults; the scale store is undefined until written.
// ---------------------------------------------------------------------------
// batch_norm_fold_into_weights_unit
// Folds batch-norm statistics into per-channel scales and fused biases.
// ---------------------------------------------------------------------------
module batch_norm_fold_into_weights_unit #(
	parameter int MAX_CHANNELS = 1024
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// channel[9:0], run_mean[41:10], run_variance[73:42], gamma_value[105:74],
	// beta_value[137:106], conv_bias[169:138], weight_value[201:170], zero[207:202]
	input  logic [bnf_pkg::IN_DATA_W-1:0]       s_tdata,
	// mode[0]
	input  logic                                s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// result_value[31:0]
	output logic [bnf_pkg::OUT_DATA_W-1:0]      m_tdata,
	// result_kind[0]
	output logic                                m_tuser,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [bnf_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [31:0]                         cfg_data
);
	import bnf_pkg::*;

	localparam int AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_RECIP  = 4'd1;
	localparam logic [3:0] ST_PROD   = 4'd2;
	localparam logic [3:0] ST_XADD   = 4'd3;
	localparam logic [3:0] ST_SQRT   = 4'd4;
	localparam logic [3:0] ST_INV    = 4'd5;
	localparam logic [3:0] ST_MEANR  = 4'd6;
	localparam logic [3:0] ST_SHIFT  = 4'd7;
	localparam logic [3:0] ST_FUSED  = 4'd8;
	localparam logic [3:0] ST_GINV   = 4'd9;
	localparam logic [3:0] ST_GFUSED = 4'd10;
	localparam logic [3:0] ST_GBETA  = 4'd11;
	localparam logic [3:0] ST_WMUL   = 4'd12;
	localparam logic [3:0] ST_OUT    = 4'd13;

	localparam logic [2:0] D_R     = 3'd0;
	localparam logic [2:0] D_T     = 3'd1;
	localparam logic [2:0] D_INV   = 3'd2;
	localparam logic [2:0] D_SH    = 3'd3;
	localparam logic [2:0] D_FUSED = 3'd4;

	logic [3:0]  state_q;
	logic        issued_q;
	logic [31:0] eps_q, rescale_q;
	logic        affine_q, bias_en_q;
	logic        kind_q;
	logic [AW-1:0] ch_q;
	logic [31:0] mean_q, var_q, gam_q, beta_q, bias_q, w_q;
	logic [31:0] r_q, t_q, inv_q, sh_q, fused_q;
	logic        m_tvalid_q;
	logic        out_kind_q;
	logic [31:0] out_value_q;

	logic        accept;
	logic        out_free;
	logic        rescale_zero;
	logic [16:0] ch_red;
	logic [AW-1:0] ch_idx;
	logic        ram_we;
	logic [31:0] ram_rdata;

	logic        op_state;
	logic [1:0]  op_c;
	logic [31:0] a_c, b_c;
	logic [2:0]  dest_c;
	logic [3:0]  nxt_c;

	fpu_req_t    fpu_req;
	fpu_rsp_t    fpu_rsp;

	assign s_tready     = (state_q == ST_IDLE);
	assign accept       = s_tvalid && s_tready;
	assign out_free     = !m_tvalid_q || m_tready;
	assign rescale_zero = (rescale_q[30:0] == 31'd0);
	assign cfg_ready    = 1'b1;
	assign m_tvalid     = m_tvalid_q;
	assign m_tdata      = out_value_q;
	assign m_tuser      = out_kind_q;

	always_comb begin
		ch_red = {7'd0, s_tdata[9:0]};
		for (int k = 9; k >= 0; k--) begin
			if ({10'd0, ch_red} >= (27'(MAX_CHANNELS) << k))
				ch_red = ch_red - 17'(27'(MAX_CHANNELS) << k);
		end
		ch_idx = ch_red[AW-1:0];
	end

	always_comb begin
		op_state = 1'b1;
		op_c     = FOP_MUL;
		a_c      = t_q;
		b_c      = r_q;
		dest_c   = D_T;
		nxt_c    = ST_IDLE;
		case (state_q)
			ST_RECIP: begin
				op_c = FOP_DIV; a_c = FP_ONE; b_c = rescale_q; dest_c = D_R; nxt_c = ST_PROD;
			end
			ST_PROD: begin
				a_c = var_q; b_c = r_q; nxt_c = ST_XADD;
			end
			ST_XADD: begin
				op_c = FOP_ADD; a_c = t_q; b_c = eps_q; nxt_c = ST_SQRT;
			end
			ST_SQRT: begin
				op_c = FOP_SQRT; a_c = t_q; nxt_c = ST_INV;
			end
			ST_INV: begin
				op_c = FOP_DIV; a_c = FP_ONE; b_c = t_q; dest_c = D_INV; nxt_c = ST_MEANR;
			end
			ST_MEANR: begin
				a_c    = bias_en_q ? mean_q : {~mean_q[31], mean_q[30:0]};
				b_c    = r_q;
				dest_c = bias_en_q ? D_T : D_SH;
				nxt_c  = bias_en_q ? ST_SHIFT : ST_FUSED;
			end
			ST_SHIFT: begin
				op_c = FOP_ADD; a_c = bias_q; b_c = {~t_q[31], t_q[30:0]};
				dest_c = D_SH; nxt_c = ST_FUSED;
			end
			ST_FUSED: begin
				a_c = sh_q; b_c = inv_q; dest_c = D_FUSED;
				nxt_c = affine_q ? ST_GINV : ST_OUT;
			end
			ST_GINV: begin
				a_c = gam_q; b_c = inv_q; dest_c = D_INV; nxt_c = ST_GFUSED;
			end
			ST_GFUSED: begin
				a_c = gam_q; b_c = fused_q; dest_c = D_FUSED; nxt_c = ST_GBETA;
			end
			ST_GBETA: begin
				op_c = FOP_ADD; a_c = fused_q; b_c = beta_q; dest_c = D_FUSED; nxt_c = ST_OUT;
			end
			ST_WMUL: begin
				a_c = w_q; b_c = ram_rdata; dest_c = D_FUSED; nxt_c = ST_OUT;
			end
			default: op_state = 1'b0;
		endcase
	end

	assign fpu_req.start = op_state && !issued_q;
	assign fpu_req.op    = op_c;
	assign fpu_req.a     = a_c;
	assign fpu_req.b     = b_c;

	assign ram_we = (state_q == ST_OUT) && out_free && (kind_q == KIND_BIAS);

	bnf_fpu u_fpu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (fpu_req),
		.rsp    (fpu_rsp)
	);

	bnf_ram #(
		.WIDTH (32),
		.DEPTH (MAX_CHANNELS)
	) u_scale_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ch_q),
		.wdata (inv_q),
		.re    (accept),
		.raddr (ch_idx),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			issued_q   <= 1'b0;
			m_tvalid_q <= 1'b0;
			eps_q      <= EPSILON_RST;
			rescale_q  <= RESCALE_RST;
			affine_q   <= 1'b1;
			bias_en_q  <= 1'b1;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_EPSILON: eps_q     <= cfg_data;
					REG_RESCALE: rescale_q <= cfg_data;
					REG_AFFINE:  affine_q  <= cfg_data[0];
					REG_BIAS:    bias_en_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (state_q == ST_OUT && out_free) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						if (s_tuser == KIND_WEIGHT) state_q <= ST_WMUL;
						else if (rescale_zero) state_q <= ST_PROD;
						else state_q <= ST_RECIP;
					end
				end
				ST_OUT: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: begin
					if (fpu_req.start) issued_q <= 1'b1;
					if (fpu_rsp.done) begin
						issued_q <= 1'b0;
						state_q  <= nxt_c;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= s_tuser;
			ch_q   <= ch_idx;
			mean_q <= s_tdata[41:10];
			var_q  <= s_tdata[73:42];
			gam_q  <= s_tdata[105:74];
			beta_q <= s_tdata[137:106];
			bias_q <= s_tdata[169:138];
			w_q    <= s_tdata[201:170];
			r_q    <= 32'd0;
		end
		if (op_state && fpu_rsp.done) begin
			case (dest_c)
				D_R:     r_q     <= fpu_rsp.value;
				D_T:     t_q     <= fpu_rsp.value;
				D_INV:   inv_q   <= fpu_rsp.value;
				D_SH:    sh_q    <= fpu_rsp.value;
				default: fused_q <= fpu_rsp.value;
			endcase
		end
		if (state_q == ST_OUT && out_free) begin
			out_kind_q  <= kind_q;
			out_value_q <= fused_q;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		fpu_rsp.done |-> issued_q)
		else $error("float unit finished without an outstanding operation");
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !issued_q)
		else $error("input accepted while an operation is outstanding");
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> ($past(state_q) == ST_OUT))
		else $error("result raised outside the output step");
endmodule

// ===== src/bnf_ram.sv =====
// ---------------------------------------------------------------------------
// bnf_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ---------------------------------------------------------------------------
module bnf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                     wdata,
	input  logic                                 re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                     rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		if (re) rdata <= mem_q[raddr];
	end
endmodule

// ===== src/bnf_fpu.sv =====
// ---------------------------------------------------------------------------
// bnf_fpu
// Shared IEEE single unit: multiply, add, iterative divide and square root.
// ---------------------------------------------------------------------------
module bnf_fpu (
	input  logic               clk,
	input  logic               arst_n,
	input  bnf_pkg::fpu_req_t  req,
	output bnf_pkg::fpu_rsp_t  rsp
);
	import bnf_pkg::*;

	localparam logic [1:0] F_IDLE  = 2'd0;
	localparam logic [1:0] F_EXEC  = 2'd1;
	localparam logic [1:0] F_ITER  = 2'd2;
	localparam logic [1:0] F_ROUND = 2'd3;

	logic [1:0]  fst_q;
	logic [1:0]  op_q;
	logic [4:0]  cnt_q;
	logic [31:0] a_q, b_q;
	logic        sign_q;
	logic [12:0] exp_q;
	logic        spec_q;
	logic [31:0] spec_val_q;
	logic [47:0] prod_q;
	logic [27:0] sum_q;
	logic [25:0] rem_q;
	logic [23:0] dvs_q;
	logic [27:0] quo_q;
	logic [53:0] rad_q;
	logic [29:0] srem_q;
	logic [26:0] root_q;

	fp_unp_t     ua, ub;
	logic [30:0] big_m, small_m;
	logic        big_s;
	logic [7:0]  eb, es, ed;
	logic [4:0]  ed5;
	logic [23:0] mb_big, mb_small;
	logic [58:0] aw;
	logic [26:0] al;
	logic        sub;
	logic [27:0] sum_c;
	logic [12:0] e_sq, e_sqp;
	logic        odd;
	logic        nx_spec;
	logic [31:0] nx_val;

	logic [25:0] dv_diff;
	logic        dv_bit;
	logic [29:0] sq_rem;
	logic [29:0] sq_trial;
	logic        sq_bit;

	logic [4:0]  lz;
	logic [27:0] norm;
	logic        r_sign;
	logic [12:0] r_exp;
	logic [26:0] r_sig;
	logic        r_st;
	logic [31:0] rnd;

	always_comb begin
		ua = fp_unpack(a_q);
		ub = fp_unpack(b_q);
		if (b_q[30:0] > a_q[30:0]) begin
			big_m = b_q[30:0]; small_m = a_q[30:0]; big_s = b_q[31];
		end else begin
			big_m = a_q[30:0]; small_m = b_q[30:0]; big_s = a_q[31];
		end
		eb       = (big_m[30:23] == 8'd0) ? 8'd1 : big_m[30:23];
		es       = (small_m[30:23] == 8'd0) ? 8'd1 : small_m[30:23];
		ed       = eb - es;
		ed5      = (ed > 8'd31) ? 5'd31 : ed[4:0];
		mb_big   = {big_m[30:23] != 8'd0, big_m[22:0]};
		mb_small = {small_m[30:23] != 8'd0, small_m[22:0]};
		aw       = {mb_small, 3'd0, 32'd0} >> ed5;
		al       = {aw[58:33], aw[32] | (|aw[31:0])};
		sub      = a_q[31] ^ b_q[31];
		sum_c    = sub ? ({1'b0, mb_big, 3'd0} - {1'b0, al})
		               : ({1'b0, mb_big, 3'd0} + {1'b0, al});
		e_sq     = ua.exp - 13'd127;
		odd      = e_sq[0];
		e_sqp    = odd ? e_sq - 13'd1 : e_sq;

		nx_spec = 1'b0;
		nx_val  = FP_CNAN;
		case (op_q)
			FOP_MUL: begin
				if (ua.nan || ub.nan || (ua.inf && ub.zero) || (ua.zero && ub.inf)) begin
					nx_spec = 1'b1;
				end else if (ua.inf || ub.inf) begin
					nx_spec = 1'b1; nx_val = {ua.sign ^ ub.sign, 8'hFF, 23'd0};
				end else if (ua.zero || ub.zero) begin
					nx_spec = 1'b1; nx_val = {ua.sign ^ ub.sign, 31'd0};
				end
			end
			FOP_ADD: begin
				if (ua.nan || ub.nan || (ua.inf && ub.inf && sub)) begin
					nx_spec = 1'b1;
				end else if (ua.inf) begin
					nx_spec = 1'b1; nx_val = a_q;
				end else if (ub.inf) begin
					nx_spec = 1'b1; nx_val = b_q;
				end else if (sum_c == 28'd0) begin
					nx_spec = 1'b1; nx_val = {a_q[31] & b_q[31], 31'd0};
				end
			end
			FOP_DIV: begin
				if (ua.nan || ub.nan || (ua.inf && ub.inf) || (ua.zero && ub.zero)) begin
					nx_spec = 1'b1;
				end else if (ua.inf || ub.zero) begin
					nx_spec = 1'b1; nx_val = {ua.sign ^ ub.sign, 8'hFF, 23'd0};
				end else if (ua.zero || ub.inf) begin
					nx_spec = 1'b1; nx_val = {ua.sign ^ ub.sign, 31'd0};
				end
			end
			default: begin
				if (ua.nan) begin
					nx_spec = 1'b1;
				end else if (ua.zero) begin
					nx_spec = 1'b1; nx_val = a_q;
				end else if (ua.sign) begin
					nx_spec = 1'b1;
				end else if (ua.inf) begin
					nx_spec = 1'b1; nx_val = a_q;
				end
			end
		endcase
	end

	always_comb begin
		dv_diff  = rem_q - {2'd0, dvs_q};
		dv_bit   = rem_q >= {2'd0, dvs_q};
		sq_rem   = {srem_q[27:0], rad_q[53:52]};
		sq_trial = {1'b0, root_q, 2'b01};
		sq_bit   = sq_rem >= sq_trial;
	end

	always_comb begin
		lz   = lzc28(sum_q);
		norm = sum_q << lz;
		r_sign = sign_q;
		case (op_q)
			FOP_MUL: begin
				if (prod_q[47]) begin
					r_exp = exp_q + 13'd1; r_sig = prod_q[47:21]; r_st = |prod_q[20:0];
				end else begin
					r_exp = exp_q; r_sig = prod_q[46:20]; r_st = |prod_q[19:0];
				end
			end
			FOP_ADD: begin
				r_exp = exp_q + 13'd1 - {8'd0, lz}; r_sig = norm[27:1]; r_st = norm[0];
			end
			FOP_DIV: begin
				if (quo_q[27]) begin
					r_exp = exp_q; r_sig = quo_q[27:1]; r_st = quo_q[0] | (rem_q != 26'd0);
				end else begin
					r_exp = exp_q - 13'd1; r_sig = quo_q[26:0]; r_st = rem_q != 26'd0;
				end
			end
			default: begin
				r_exp = exp_q; r_sig = root_q; r_st = srem_q != 30'd0;
			end
		endcase
		rnd = fp_round(r_sign, r_exp, r_sig, r_st);
	end

	assign rsp.done  = (fst_q == F_ROUND);
	assign rsp.value = spec_q ? spec_val_q : rnd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fst_q <= F_IDLE;
			op_q  <= FOP_MUL;
			cnt_q <= 5'd0;
		end else begin
			case (fst_q)
				F_IDLE: begin
					if (req.start) begin
						op_q  <= req.op;
						fst_q <= F_EXEC;
					end
				end
				F_EXEC: begin
					if (nx_spec || op_q == FOP_MUL || op_q == FOP_ADD) begin
						fst_q <= F_ROUND;
					end else begin
						fst_q <= F_ITER;
						cnt_q <= (op_q == FOP_DIV) ? 5'd27 : 5'd26;
					end
				end
				F_ITER: begin
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == 5'd0) fst_q <= F_ROUND;
				end
				default: fst_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (fst_q == F_IDLE && req.start) begin
			a_q <= req.a;
			b_q <= req.b;
		end
		if (fst_q == F_EXEC) begin
			spec_q     <= nx_spec;
			spec_val_q <= nx_val;
			case (op_q)
				FOP_MUL: begin
					sign_q <= ua.sign ^ ub.sign;
					exp_q  <= ua.exp + ub.exp - 13'd127;
					prod_q <= ua.mant * ub.mant;
				end
				FOP_ADD: begin
					sign_q <= big_s;
					exp_q  <= {5'd0, eb};
					sum_q  <= sum_c;
				end
				FOP_DIV: begin
					sign_q <= ua.sign ^ ub.sign;
					exp_q  <= ua.exp - ub.exp + 13'd127;
					rem_q  <= {2'd0, ua.mant};
					dvs_q  <= ub.mant;
					quo_q  <= 28'd0;
				end
				default: begin
					sign_q <= 1'b0;
					exp_q  <= {e_sqp[12], e_sqp[12:1]} + 13'd127;
					rad_q  <= odd ? {ua.mant, 1'b0, 29'd0} : {1'b0, ua.mant, 29'd0};
					srem_q <= 30'd0;
					root_q <= 27'd0;
				end
			endcase
		end
		if (fst_q == F_ITER) begin
			if (op_q == FOP_DIV) begin
				rem_q <= dv_bit ? {dv_diff[24:0], 1'b0} : {rem_q[24:0], 1'b0};
				quo_q <= {quo_q[26:0], dv_bit};
			end else begin
				srem_q <= sq_bit ? sq_rem - sq_trial : sq_rem;
				root_q <= {root_q[25:0], sq_bit};
				rad_q  <= {rad_q[51:0], 2'b00};
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(fst_q == F_ITER) |-> (op_q == FOP_DIV || op_q == FOP_SQRT))
		else $error("multiply or add entered the iteration phase");
	assert property (@(posedge clk) disable iff (!arst_n)
		(fst_q == F_ROUND) |=> (fst_q == F_IDLE))
		else $error("result phase lasted more than one cycle");
	assert property (@(posedge clk) disable iff (!arst_n)
		(fst_q == F_ITER && op_q == FOP_SQRT) |-> (cnt_q <= 5'd26))
		else $error("square root step count out of range");
endmodule

// ===== tb/batch_norm_fold_into_weights_unit_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// batch_norm_fold_into_weights_unit_tb
// Drives statistics and weight requests into the fold unit and checks
// every fused bias and scaled weight. The expected values come from an
// integer model of IEEE single arithmetic with round to nearest even.
// A directed table goes first. Random phases follow, each under its own
// register setting, with one of three idle patterns on both streams.
// ---------------------------------------------------------------------------
module batch_norm_fold_into_weights_unit_tb;
	import bnf_pkg::*;

	localparam int     N_CH        = 1024;
	localparam int     N_PHASES    = 7;
	localparam int     PHASE_ITEMS = 250;
	localparam int     SETTLE      = 160;
	localparam longint CYCLE_LIMIT = 3000000;

	typedef struct {
		logic        kind;
		logic [31:0] value;
	} result_t;

	typedef struct {
		logic        mode;
		logic [9:0]  ch;
		logic [31:0] mean;
		logic [31:0] variance;
		logic [31:0] gamma;
		logic [31:0] beta;
		logic [31:0] bias;
		logic [31:0] weight;
		bit          fixed;
		logic [31:0] fixed_value;
	} request_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic                  s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tuser;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [31:0]           cfg_data;

	logic [31:0] eps_reg;
	logic [31:0] rescale_reg;
	logic        affine_reg;
	logic        bias_reg;
	logic [31:0] channel_scale [N_CH];
	bit          scale_written [N_CH];
	int          written_list [$];
	result_t     pending_results [$];

	int     send_idle;
	int     recv_idle;
	bit     burst;
	int     mismatch_count;
	int     checked_count;
	int     stats_sent;
	int     weights_sent;
	longint cycle_count;

	batch_norm_fold_into_weights_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #1 clk = ~clk;

	// IEEE single arithmetic on integers
	function automatic bit f_is_nan(input logic [31:0] b);
		return (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
	endfunction

	function automatic bit f_is_inf(input logic [31:0] b);
		return (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
	endfunction

	function automatic void f_split(input logic [31:0] b, output logic [127:0] m, output int e);
		if (b[30:23] != 8'd0) begin
			m = {104'd0, 1'b1, b[22:0]};
			e = int'(b[30:23]) - 150;
		end else begin
			m = {105'd0, b[22:0]};
			e = -149;
		end
	endfunction

	function automatic logic [31:0] f_round(input bit s, input logic [127:0] m, input int e,
		input bit st);
		int          p;
		int          ex;
		int          sh;
		logic [127:0] q;
		bit          g;
		bit          rb;
		longint      t;
		if (m == 0) return {s, 31'd0};
		p = 127;
		while (!m[p]) p--;
		ex = p + e;
		if (ex < -126) ex = -126;
		sh = (ex - 23) - e;
		if (sh <= 0) begin
			q  = m << (-sh);
			g  = 1'b0;
			rb = st;
		end else if (sh > 128) begin
			q  = '0;
			g  = 1'b0;
			rb = 1'b1;
		end else begin
			q  = m >> sh;
			g  = m[sh-1];
			rb = st | ((m & ((128'd1 << (sh - 1)) - 128'd1)) != 0);
		end
		if (g && (rb || q[0])) q = q + 128'd1;
		t = (longint'(ex + 126) << 23) + longint'(q[31:0]);
		if (t >= 64'h7F800000) return {s, 8'hFF, 23'd0};
		return {s, t[30:0]};
	endfunction

	function automatic logic [31:0] f_mul(input logic [31:0] a, input logic [31:0] b);
		bit           s;
		logic [127:0] ma;
		logic [127:0] mb;
		int           ea;
		int           eb;
		s = a[31] ^ b[31];
		if (f_is_nan(a) || f_is_nan(b)) return FP_CNAN;
		if (f_is_inf(a) || f_is_inf(b)) begin
			if (a[30:0] == 31'd0 || b[30:0] == 31'd0) return FP_CNAN;
			return {s, 8'hFF, 23'd0};
		end
		if (a[30:0] == 31'd0 || b[30:0] == 31'd0) return {s, 31'd0};
		f_split(a, ma, ea);
		f_split(b, mb, eb);
		return f_round(s, ma * mb, ea + eb, 1'b0);
	endfunction

	function automatic logic [31:0] f_add(input logic [31:0] a, input logic [31:0] b);
		logic [127:0] ma;
		logic [127:0] mb;
		logic [127:0] tm;
		int           ea;
		int           eb;
		int           te;
		bit           sa;
		bit           sb;
		bit           ts;
		if (f_is_nan(a) || f_is_nan(b)) return FP_CNAN;
		if (f_is_inf(a) && f_is_inf(b)) return (a[31] == b[31]) ? a : FP_CNAN;
		if (f_is_inf(a)) return a;
		if (f_is_inf(b)) return b;
		if (a[30:0] == 31'd0 && b[30:0] == 31'd0) return {a[31] & b[31], 31'd0};
		if (a[30:0] == 31'd0) return b;
		if (b[30:0] == 31'd0) return a;
		f_split(a, ma, ea);
		f_split(b, mb, eb);
		sa = a[31];
		sb = b[31];
		if (eb > ea) begin
			tm = ma; ma = mb; mb = tm;
			te = ea; ea = eb; eb = te;
			ts = sa; sa = sb; sb = ts;
		end
		// the far smaller operand only decides the sticky side of rounding
		if (ea - eb > 50) begin
			mb = 128'd1;
			eb = ea - 30;
		end
		ma = ma << (ea - eb);
		if (sa == sb) return f_round(sa, ma + mb, eb, 1'b0);
		if (ma == mb) return 32'd0;
		if (ma > mb) return f_round(sa, ma - mb, eb, 1'b0);
		return f_round(sb, mb - ma, eb, 1'b0);
	endfunction

	function automatic logic [31:0] f_div(input logic [31:0] a, input logic [31:0] b);
		bit           s;
		logic [127:0] ma;
		logic [127:0] mb;
		logic [127:0] q;
		int           ea;
		int           eb;
		s = a[31] ^ b[31];
		if (f_is_nan(a) || f_is_nan(b)) return FP_CNAN;
		if (f_is_inf(a) && f_is_inf(b)) return FP_CNAN;
		if (a[30:0] == 31'd0 && b[30:0] == 31'd0) return FP_CNAN;
		if (f_is_inf(a) || b[30:0] == 31'd0) return {s, 8'hFF, 23'd0};
		if (f_is_inf(b) || a[30:0] == 31'd0) return {s, 31'd0};
		f_split(a, ma, ea);
		f_split(b, mb, eb);
		ma = ma << 80;
		q  = ma / mb;
		return f_round(s, q, ea - eb - 80, (ma % mb) != 0);
	endfunction

	// positive finite nonzero argument only
	function automatic logic [31:0] f_sqrt(input logic [31:0] a);
		logic [127:0] m;
		logic [127:0] x;
		logic [127:0] r;
		logic [127:0] step;
		int           e;
		f_split(a, m, e);
		if (e % 2 != 0) begin
			m = m << 1;
			e = e - 1;
		end
		m    = m << 60;
		e    = e - 60;
		x    = m;
		r    = '0;
		step = 128'd1 << 126;
		while (step > x) step = step >> 2;
		while (step != 0) begin
			if (x >= r + step) begin
				x = x - (r + step);
				r = (r >> 1) + step;
			end else begin
				r = r >> 1;
			end
			step = step >> 2;
		end
		return f_round(1'b0, r, e / 2, x != 0);
	endfunction

	function automatic logic [31:0] inv_sqrt(input logic [31:0] x);
		if (f_is_nan(x)) return FP_CNAN;
		if (x[30:0] == 31'd0) return {x[31], 8'hFF, 23'd0};
		if (x[31]) return FP_CNAN;
		if (f_is_inf(x)) return 32'd0;
		return f_div(FP_ONE, f_sqrt(x));
	endfunction

	function automatic logic [31:0] canon(input logic [31:0] v);
		return f_is_nan(v) ? FP_CNAN : v;
	endfunction

	function automatic result_t fold_predict(input request_t rq);
		result_t     res;
		logic [31:0] r;
		logic [31:0] x;
		logic [31:0] inv;
		logic [31:0] shifted;
		logic [31:0] fused;
		if (rq.mode == KIND_WEIGHT) begin
			res.kind  = KIND_WEIGHT;
			res.value = canon(f_mul(rq.weight, channel_scale[rq.ch]));
			return res;
		end
		r   = (rescale_reg[30:0] != 31'd0) ? f_div(FP_ONE, rescale_reg) : 32'd0;
		x   = f_add(f_mul(rq.variance, r), eps_reg);
		inv = inv_sqrt(x);
		if (bias_reg) begin
			shifted = f_add(rq.bias, f_mul(rq.mean, r) ^ 32'h80000000);
		end else begin
			shifted = f_mul(rq.mean ^ 32'h80000000, r);
		end
		fused = f_mul(shifted, inv);
		if (affine_reg) begin
			inv   = f_mul(rq.gamma, inv);
			fused = f_add(f_mul(rq.gamma, fused), rq.beta);
		end
		channel_scale[rq.ch] = inv;
		if (!scale_written[rq.ch]) written_list = {written_list, int'(rq.ch)};
		scale_written[rq.ch] = 1'b1;
		res.kind  = KIND_BIAS;
		res.value = canon(fused);
		return res;
	endfunction

	function automatic logic [31:0] rand_float(input bit positive);
		logic [31:0] v;
		logic [31:0] specials [10];
		specials = '{32'h00000000, 32'h80000000, 32'h7F800000, 32'hFF800000, 32'h7FC00001,
			32'h3F800000, 32'h00000001, 32'h007FFFFF, 32'h7F7FFFFF, 32'h00800000};
		case ($urandom_range(9))
			0: v = specials[$urandom_range(9)];
			1: v = $urandom;
			default: v = {1'($urandom), 8'($urandom_range(140, 110)), 23'($urandom)};
		endcase
		if (positive && $urandom_range(3) != 0) v[31] = 1'b0;
		return v;
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_EPSILON: eps_reg     = val;
			REG_RESCALE: rescale_reg = val;
			REG_AFFINE:  affine_reg  = val[0];
			REG_BIAS:    bias_reg    = val[0];
			default: ;
		endcase
	endtask

	task automatic drain_results;
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic send_request(input request_t rq);
		result_t res;
		while (!burst && $urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= rq.mode;
		s_tdata  <= {6'd0, rq.weight, rq.bias, rq.beta, rq.gamma, rq.variance, rq.mean, rq.ch};
		do @(posedge clk); while (!s_tready);
		res = fold_predict(rq);
		if (rq.fixed) res.value = rq.fixed_value;
		pending_results = {pending_results, res};
		if (rq.mode == KIND_WEIGHT) weights_sent++;
		else stats_sent++;
	endtask

	function automatic request_t rand_request();
		request_t rq;
		rq.fixed    = 1'b0;
		rq.mode     = ($urandom_range(99) < 55) ? KIND_WEIGHT : KIND_BIAS;
		rq.mean     = rand_float(1'b0);
		rq.variance = rand_float(1'b1);
		rq.gamma    = rand_float(1'b0);
		rq.beta     = rand_float(1'b0);
		rq.bias     = rand_float(1'b0);
		rq.weight   = rand_float(1'b0);
		if (rq.mode == KIND_WEIGHT)
			rq.ch = 10'(written_list[$urandom_range(written_list.size() - 1)]);
		else if ($urandom_range(1))
			rq.ch = 10'($urandom_range(15));
		else
			rq.ch = 10'($urandom_range(N_CH - 1));
		return rq;
	endfunction

	always @(posedge clk) begin
		result_t want;
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
			$display("Test completed with failures");
			$finish;
		end
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count < 50)
					$display("%0t: unexpected result kind=%0d value=%h", $time, m_tuser, m_tdata);
			end else begin
				want = pending_results.pop_front();
				checked_count++;
				if (m_tuser !== want.kind || m_tdata !== want.value) begin
					mismatch_count++;
					if (mismatch_count < 50)
						$display("%0t: mismatch expected kind=%0d value=%h actual kind=%0d value=%h",
							$time, want.kind, want.value, m_tuser, m_tdata);
				end
			end
		end
		if (arst_n) m_tready <= burst || ($urandom_range(99) >= recv_idle);
	end

	initial begin
		request_t    directed [16];
		request_t    rq;
		logic [31:0] eps_set [N_PHASES];
		logic [31:0] rsc_set [N_PHASES];
		bit          aff_set [N_PHASES];
		bit          bia_set [N_PHASES];
		clk            = 1'b0;
		arst_n         = 1'b0;
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		s_tuser        = 1'b0;
		m_tready       = 1'b0;
		cfg_valid      = 1'b0;
		cfg_index      = REG_EPSILON;
		cfg_data       = '0;
		eps_reg        = EPSILON_RST;
		rescale_reg    = RESCALE_RST;
		affine_reg     = 1'b1;
		bias_reg       = 1'b1;
		burst          = 1'b0;
		send_idle      = 16;
		recv_idle      = 79;
		mismatch_count = 0;
		checked_count  = 0;
		stats_sent     = 0;
		weights_sent   = 0;
		cycle_count    = 0;
		foreach (channel_scale[i]) begin
			channel_scale[i] = '0;
			scale_written[i] = 1'b0;
		end

		// mode ch mean var gamma beta bias weight fixed expected
		directed = '{
			'{KIND_BIAS,   10'd0,    32'h0, 32'h3F800000, 32'h3F800000, 32'h0, 32'h0, 32'h0,
				1'b0, 32'h0},
			'{KIND_WEIGHT, 10'd0,    32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h3F800000, 1'b0, 32'h0},
			'{KIND_BIAS,   10'd1023, 32'h0, 32'hBF800000, 32'h3F800000, 32'h0, 32'h0, 32'h0,
				1'b1, FP_CNAN},
			'{KIND_WEIGHT, 10'd1023, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h40000000, 1'b1, FP_CNAN},
			'{KIND_BIAS,   10'd5,    32'h0, 32'h7F800000, 32'h3F800000, 32'h0, 32'h3F800000,
				32'h0, 1'b1, 32'h00000000},
			'{KIND_WEIGHT, 10'd5,    32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h7F7FFFFF, 1'b1,
				32'h00000000},
			'{KIND_WEIGHT, 10'd5,    32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h7F800000, 1'b1, FP_CNAN},
			'{KIND_BIAS,   10'd2,    32'h0, 32'h7FC00000, 32'h3F800000, 32'h0, 32'h0, 32'h0,
				1'b1, FP_CNAN},
			'{KIND_BIAS,   10'd3,    32'h7F7FFFFF, 32'h7F7FFFFF, 32'h7F7FFFFF, 32'h7F7FFFFF,
				32'h7F7FFFFF, 32'h0, 1'b0, 32'h0},
			'{KIND_BIAS,   10'd4,    32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 32'h0},
			'{KIND_BIAS,   10'd6,    32'hFFFFFFFF, 32'h3F800000, 32'h3F800000, 32'h0, 32'h0,
				32'h0, 1'b1, FP_CNAN},
			'{KIND_WEIGHT, 10'd3,    32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'hFFFFFFFF, 1'b1, FP_CNAN},
			'{KIND_WEIGHT, 10'd4,    32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h00000001, 1'b0, 32'h0},
			'{KIND_WEIGHT, 10'd0,    32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h80000000, 1'b0, 32'h0},
			'{KIND_BIAS,   10'd7,    32'hBF800000, 32'h00000001, 32'hC0000000, 32'h40400000,
				32'h80000000, 32'h0, 1'b0, 32'h0},
			'{KIND_WEIGHT, 10'd7,    32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'hC2F60000, 1'b0, 32'h0}
		};

		eps_set = '{EPSILON_RST, 32'h00000000, 32'h7F7FFFFF, 32'h00000001, $urandom,
			32'hFFFFFFFF, 32'h3DCCCCCD};
		rsc_set = '{RESCALE_RST, 32'h00000000, 32'h80000000, 32'h7F800000, 32'h40800000,
			32'h00000001, 32'hBF000000};
		aff_set = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
		bia_set = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) send_request(directed[i]);
		drain_results();

		for (int ph = 0; ph < N_PHASES; ph++) begin
			write_reg(REG_EPSILON, eps_set[ph]);
			write_reg(REG_RESCALE, rsc_set[ph]);
			write_reg(REG_AFFINE, {31'd0, aff_set[ph]});
			write_reg(REG_BIAS, {31'd0, bia_set[ph]});
			cfg_valid <= 1'b0;
			if (ph < 3) begin
				send_idle = 16;
				recv_idle = 79;
			end else if (ph < 5) begin
				send_idle = 79;
				recv_idle = 16;
			end else begin
				send_idle = 0;
				recv_idle = 0;
			end
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				burst = (n % 100) < 20;
				if (ph == 1 && n == PHASE_ITEMS / 2) begin
					s_tvalid <= 1'b0;
					while (pending_results.size() != 0) @(posedge clk);
				end
				rq = rand_request();
				send_request(rq);
			end
			burst = 1'b0;
			drain_results();
		end

		$display("Covered %0d statistics and %0d weight requests over %0d register settings,",
			stats_sent, weights_sent, N_PHASES + 1);
		$display("%0d results checked, %0d mismatches", checked_count, mismatch_count);
		if (mismatch_count == 0 && pending_results.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
src/bnf_pkg.sv
src/bnf_ram.sv
src/bnf_fpu.sv
src/batch_norm_fold_into_weights_unit.sv
tb/batch_norm_fold_into_weights_unit_tb.sv
